### design/uart_drb_pkg.sv
// Shared types and codes for the UART dual ring buffer.
package uart_drb_pkg;

  // Event codes carried on the kind field
  localparam logic [1:0] KIND_RX    = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_PUT   = 2'd2;
  localparam logic [1:0] KIND_TXRDY = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // perform the buffer operation
  } dp_cmd_t;

endpackage

### design/uart_drb_ctrl.sv
// Controller state machine: sequences capture, execute and result delivery.
module uart_drb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uart_drb_pkg::dp_cmd_t cmd
);
  import uart_drb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.exec = (state == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_EXEC;
            in_ready <= 1'b0;
          end
        end
        ST_EXEC: begin
          state     <= ST_OUT;
          out_valid <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= ST_IDLE;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

### design/uart_drb_dp.sv
// Datapath: both ring buffers, their pointers, interrupt flags and result registers.
module uart_drb_dp #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  uart_drb_pkg::dp_cmd_t cmd,
  input  logic [1:0]            kind,
  input  logic [7:0]            byte_in,
  output logic [7:0]            byte_out,
  output logic                  byte_valid,
  output logic                  accepted,
  output logic                  rx_irq_enabled,
  output logic                  tx_irq_enabled
);
  import uart_drb_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_DEPTH - 1);

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [7:0] rx_mem [BUFFER_DEPTH];
  logic [7:0] tx_mem [BUFFER_DEPTH];

  logic [1:0]    kind_r;
  logic [7:0]    byte_r;
  logic [PW-1:0] rx_wp, rx_rp, tx_wp, tx_rp;
  logic          rx_irq, tx_irq;
  logic [7:0]    rx_rdata, tx_rdata;
  logic          sel_tx;

  logic [PW-1:0] rx_wp_next, rx_rp_next, tx_wp_next, tx_rp_next;
  logic          rx_full, rx_empty, tx_full, tx_empty;
  logic          rx_we, rx_re, tx_we, tx_re;

  always_comb begin
    rx_wp_next = advance(rx_wp);
    rx_rp_next = advance(rx_rp);
    tx_wp_next = advance(tx_wp);
    tx_rp_next = advance(tx_rp);
    rx_full    = (rx_wp_next == rx_rp);
    rx_empty   = (rx_wp == rx_rp);
    tx_full    = (tx_wp_next == tx_rp);
    tx_empty   = (tx_wp == tx_rp);
    rx_we      = cmd.exec && (kind_r == KIND_RX)    && !rx_full;
    rx_re      = cmd.exec && (kind_r == KIND_GET)   && !rx_empty;
    tx_we      = cmd.exec && (kind_r == KIND_PUT)   && !tx_full;
    tx_re      = cmd.exec && (kind_r == KIND_TXRDY) && !tx_empty;
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wp_next] <= byte_r;
    end
    if (rx_re) begin
      rx_rdata <= rx_mem[rx_rp_next];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wp_next] <= byte_r;
    end
    if (tx_re) begin
      tx_rdata <= tx_mem[tx_rp_next];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      byte_r <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp  <= '0;
      rx_rp  <= '0;
      tx_wp  <= '0;
      tx_rp  <= '0;
      rx_irq <= 1'b1;
      tx_irq <= 1'b0;
    end else if (cmd.exec) begin
      unique case (kind_r)
        KIND_RX: begin
          if (rx_full) begin
            rx_irq <= 1'b0;
          end else begin
            rx_wp <= rx_wp_next;
          end
        end
        KIND_GET: begin
          if (!rx_empty) begin
            rx_rp  <= rx_rp_next;
            rx_irq <= 1'b1;
          end
        end
        KIND_PUT: begin
          if (!tx_full) begin
            tx_wp  <= tx_wp_next;
            tx_irq <= 1'b1;
          end
        end
        KIND_TXRDY: begin
          if (tx_empty) begin
            tx_irq <= 1'b0;
          end else begin
            tx_rp <= tx_rp_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields, held until the next transaction executes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      byte_valid <= rx_re || tx_re;
      accepted   <= rx_we || tx_we;
      sel_tx     <= (kind_r == KIND_TXRDY);
    end
  end

  assign byte_out       = !byte_valid ? 8'd0 : (sel_tx ? tx_rdata : rx_rdata);
  assign rx_irq_enabled = rx_irq;
  assign tx_irq_enabled = tx_irq;

endmodule

### design/uart_dual_ring_buffer_unit.sv
// Sequence: capture at the accept edge, then the execute state, result valid in the cycle after that.
// A new transaction is accepted only after the previous result has been taken, a pace
// set by the capture/execute/deliver sequence around the registered buffer read.
// Reset (rst, synchronous): pointers cleared so both rings are empty,
// receive interrupt flag set, transmit interrupt flag cleared; buffer contents kept.
module uart_dual_ring_buffer_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       byte_valid,
  output logic       accepted,
  output logic       rx_irq_enabled,
  output logic       tx_irq_enabled
);
  import uart_drb_pkg::*;

  dp_cmd_t cmd;

  uart_drb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  uart_drb_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .kind           (kind),
    .byte_in        (byte_in),
    .byte_out       (byte_out),
    .byte_valid     (byte_valid),
    .accepted       (accepted),
    .rx_irq_enabled (rx_irq_enabled),
    .tx_irq_enabled (tx_irq_enabled)
  );

endmodule

### design/uart_drb_chk.sv
// Port-level checker for the UART dual ring buffer, bound to the top level.
module uart_drb_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] byte_out,
  input logic       byte_valid,
  input logic       accepted
);

  // One transaction in flight: never ready for input while a result is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (byte_out == 8'd0))
    else $error("byte_out nonzero without a popped byte");

  // A pop never reports a store
  a_pop_not_store: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> !accepted)
    else $error("popped byte and accepted both set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(byte_out)))
    else $error("stalled result changed");

endmodule

bind uart_dual_ring_buffer_unit uart_drb_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .byte_out   (byte_out),
  .byte_valid (byte_valid),
  .accepted   (accepted)
);

### dv/uart_dual_ring_buffer_unit_tb.sv
// Self-checking testbench for the UART dual ring buffer unit.
`timescale 1ns / 1ps

module uart_dual_ring_buffer_unit_tb;
  import uart_drb_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       drain_first;  // hold off until every pending result is back
  } uart_event_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       accepted;
    logic       rx_irq;
    logic       tx_irq;
  } ring_resp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = KIND_RX;
  logic [7:0] byte_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       accepted;
  logic       rx_irq_enabled;
  logic       tx_irq_enabled;

  uart_event_t event_queue[$];
  ring_resp_t  pending_results[$];
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          error_count = 0;
  int          stall_cycles = 0;

  // Shadow copy of both rings
  logic [7:0]  rx_ring[DEPTH];
  logic [7:0]  tx_ring[DEPTH];
  int unsigned rx_wr = 0;
  int unsigned rx_rd = 0;
  int unsigned tx_wr = 0;
  int unsigned tx_rd = 0;
  logic        rx_flag = 1'b1;
  logic        tx_flag = 1'b0;

  uart_dual_ring_buffer_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .byte_in       (byte_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .byte_out      (byte_out),
    .byte_valid    (byte_valid),
    .accepted      (accepted),
    .rx_irq_enabled(rx_irq_enabled),
    .tx_irq_enabled(tx_irq_enabled)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned next_slot(input int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  // Applies one event to the shadow rings and returns the response it causes.
  function automatic ring_resp_t apply_ring_event(input logic [1:0] k, input logic [7:0] d);
    ring_resp_t  r;
    int unsigned nxt;
    r = '0;
    case (k)
      KIND_RX: begin
        nxt = next_slot(rx_wr);
        if (nxt == rx_rd) begin
          rx_flag = 1'b0;  // overrun: byte dropped
        end else begin
          rx_wr = nxt;
          rx_ring[nxt] = d;
          r.accepted = 1'b1;
        end
      end
      KIND_GET: begin
        if (rx_wr != rx_rd) begin
          rx_rd = next_slot(rx_rd);
          r.byte_out = rx_ring[rx_rd];
          r.byte_valid = 1'b1;
          rx_flag = 1'b1;
        end
      end
      KIND_PUT: begin
        nxt = next_slot(tx_wr);
        if (nxt != tx_rd) begin
          tx_ring[nxt] = d;
          tx_wr = nxt;
          tx_flag = 1'b1;
          r.accepted = 1'b1;
        end
      end
      default: begin
        if (tx_wr != tx_rd) begin
          tx_rd = next_slot(tx_rd);
          r.byte_out = tx_ring[tx_rd];
          r.byte_valid = 1'b1;
        end else begin
          tx_flag = 1'b0;
        end
      end
    endcase
    r.rx_irq = rx_flag;
    r.tx_irq = tx_flag;
    return r;
  endfunction

  // Driver
  always @(posedge clk) begin : drive
    uart_event_t ev;
    logic        go;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_ring_event(kind, byte_in));
      end
      if (!in_valid || in_ready) begin
        go = (event_queue.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
        if (go && event_queue[0].drain_first && pending_results.size() != 0) begin
          go = 1'b0;
        end
        if (go) begin
          ev = event_queue.pop_front();
          kind <= ev.kind;
          byte_in <= ev.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin : monitor
    ring_resp_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected");
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (byte_out !== exp_r.byte_out) begin
            $error("byte_out: expected %0h, actual %0h", exp_r.byte_out, byte_out);
            error_count++;
          end
          if (byte_valid !== exp_r.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", exp_r.byte_valid, byte_valid);
            error_count++;
          end
          if (accepted !== exp_r.accepted) begin
            $error("accepted: expected %0b, actual %0b", exp_r.accepted, accepted);
            error_count++;
          end
          if (rx_irq_enabled !== exp_r.rx_irq) begin
            $error("rx_irq_enabled: expected %0b, actual %0b", exp_r.rx_irq, rx_irq_enabled);
            error_count++;
          end
          if (tx_irq_enabled !== exp_r.tx_irq) begin
            $error("tx_irq_enabled: expected %0b, actual %0b", exp_r.tx_irq, tx_irq_enabled);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_event(input logic [1:0] k, input logic [7:0] d, input logic hold);
    uart_event_t ev;
    ev.kind = k;
    ev.data = d;
    ev.drain_first = hold;
    event_queue.push_back(ev);
  endtask

  // Run of events dominated by one kind; pct of 0 gives a uniform mix.
  task automatic add_burst(input logic [1:0] major, input int n, input int pct,
                           input logic hold);
    logic [1:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(99) < pct) ? major : 2'($urandom_range(3));
      add_event(k, 8'($urandom_range(255)), hold && (i == 0));
    end
  endtask

  task automatic add_random(input int n, input logic hold);
    int         done;
    int         len;
    logic [1:0] major;
    done = 0;
    while (done < n) begin
      len = $urandom_range(15, 90);
      major = 2'($urandom_range(3));
      add_burst(major, len, ($urandom_range(4) == 0) ? 0 : 85,
                (done == 0) ? hold : ($urandom_range(3) == 0));
      done += len;
    end
  endtask

  task automatic wait_all_sent();
    while (event_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 25;
    receiver_idle_pct = 50;

    // Directed: empty rings, byte extremes, every kind, ignored data on pops
    add_event(KIND_GET,   8'hFF, 1'b0);
    add_event(KIND_TXRDY, 8'hFF, 1'b0);
    add_event(KIND_RX,    8'h00, 1'b0);
    add_event(KIND_RX,    8'hFF, 1'b0);
    add_event(KIND_GET,   8'h5A, 1'b0);
    add_event(KIND_GET,   8'h00, 1'b0);
    add_event(KIND_GET,   8'hA5, 1'b0);
    add_event(KIND_PUT,   8'hFF, 1'b0);
    add_event(KIND_PUT,   8'h00, 1'b0);
    add_event(KIND_TXRDY, 8'h33, 1'b0);
    add_event(KIND_TXRDY, 8'hCC, 1'b0);
    add_event(KIND_TXRDY, 8'h00, 1'b0);
    add_event(KIND_PUT,   8'h5A, 1'b0);
    add_event(KIND_RX,    8'hA5, 1'b0);
    add_event(KIND_GET,   8'h00, 1'b1);

    // Overrun the receive ring and drain it past empty, then reject puts on a
    // full transmit ring and drain that past empty too, so the pointers wrap
    add_burst(KIND_RX,    DEPTH + 4, 100, 1'b0);
    add_burst(KIND_GET,   DEPTH + 2, 100, 1'b0);
    add_burst(KIND_PUT,   DEPTH + 4, 100, 1'b0);
    add_burst(KIND_TXRDY, DEPTH + 2, 100, 1'b0);
    add_random(100, 1'b1);
    wait_all_sent();

    sender_idle_pct = 50;
    receiver_idle_pct = 25;
    add_random(120, 1'b1);
    wait_all_sent();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    add_random(120, 1'b1);
    wait_all_sent();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
